// ----- rtl/core/life_cellular_automaton_grid_core_defines.svh -----
// Assertion macros for the life grid core.
// Depends on a clk and an active-low arst_n in the scope that uses them.
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_CORE_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is applied
`define LCAG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is applied
`define LCAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lcag_pkg.sv -----
// Shared types and constants for the life grid core.
// No dependencies; imported by the core and by lcag_cell.
`default_nettype none

package lcag_pkg;

	// grid geometry
	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 128;
	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int COORD_W  = 7;
	localparam int CFG_W    = 8;
	localparam int CFG_IW   = 1;
	localparam int ACT_W    = 3;
	localparam int CNT_W    = 4;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_COLS = 1'd0;
	localparam logic [CFG_IW-1:0] REG_ROWS = 1'd1;

	// reset values of the registers
	localparam logic [CFG_W-1:0] COLS_RESET = 8'd100;
	localparam logic [CFG_W-1:0] ROWS_RESET = 8'd100;

	// command codes
	localparam logic [ACT_W-1:0] ACT_SET     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TOGGLE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_WIPE    = 3'd5;

	// B3/S23 neighbour counts
	localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
	localparam logic [CNT_W-1:0] KEEP_COUNT  = 4'd2;

	// one column of the three-row window
	typedef struct packed {
		logic top;
		logic mid;
		logic bot;
	} win_t;

	// control of the cell chain
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/life_cellular_automaton_grid_core.sv -----
// Life (B3/S23) cell grid core.
// Depends on lcag_pkg, lcag_ram, lcag_cell and the core's assertion header.
//
// Use: commands enter on the in_valid/in_stall channel (action, col, row),
// one result beat per command leaves on out_valid/out_stall (cell_value,
// coord_error). cols_in_use and rows_in_use are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the core is
// idle, which the core itself does not enforce. The grid is a 128 x 128 bit
// RAM, one row per word, with a valid flag per row; a row whose flag is clear
// reads as dead, so reset and wipe act at once. A command with a bad
// coordinate, wipe or unknown code goes straight to the push state; set,
// clear, toggle and read do one RAM read, then a read-modify-write of the
// row; an advance runs a sweep that reads one row a cycle into a chain of
// one cell per column holding a three-row window. One command is in work at a
// time; in_stall is high from accept until its result is in the output
// register. The output register holds a result while out_stall is high, and
// a new command is taken meanwhile; its result waits until the beat leaves.
// Reset kills every cell and loads 100 into both size registers.
`default_nettype none

module life_cellular_automaton_grid_core
	import lcag_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CFG_IW-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [ACT_W-1:0]   action,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic [COORD_W-1:0] row,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    cell_value,
	output logic                    coord_error
);

	`include "life_cellular_automaton_grid_core_defines.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CELL = 2'd1;
	localparam logic [1:0] ST_GEN  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0]          state_q;
	logic [CFG_W-1:0]    cols_q;
	logic [CFG_W-1:0]    rows_q;
	logic [CFG_W-1:0]    cols_act;
	logic [CFG_W-1:0]    rows_act;
	logic [ACT_W-1:0]    act_q;
	logic [COORD_W-1:0]  col_q;
	logic [COORD_W-1:0]  row_q;
	logic                res_value_q;
	logic                res_err_q;
	logic                out_valid_q;
	logic                cell_value_q;
	logic                coord_error_q;
	logic [MAX_ROWS-1:0] row_valid_q;
	logic [CFG_W-1:0]    ptr_q;
	logic [CFG_W-1:0]    ptr_s1;
	logic                gen_s1_q;
	logic                rd_vld_s1;
	logic                in_accept;
	logic                coord_bad;
	logic                cell_cmd;
	logic                gen_issue;
	logic                gen_done;
	logic                push_ok;
	logic                ram_we;
	logic [ROW_AW-1:0]   ram_waddr;
	logic [MAX_COLS-1:0] ram_wdata;
	logic                ram_re;
	logic [ROW_AW-1:0]   ram_raddr;
	logic [MAX_COLS-1:0] ram_rdata;
	logic [MAX_COLS-1:0] row_s1;
	logic [MAX_COLS-1:0] cell_row;
	logic                old_bit;
	logic                new_bit;
	logic [MAX_COLS-1:0] col_active;
	logic [MAX_COLS-1:0] bot_raw;
	logic [MAX_COLS-1:0] next_row;
	win_t                own_bits [MAX_COLS];
	cell_ctl_t           cell_ctl;

	// clamp the size registers to the stored grid
	assign cols_act = (cols_q > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_q;
	assign rows_act = (rows_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_q;

	// handshake and command decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign coord_bad = ({1'b0, col} >= cols_act) || ({1'b0, row} >= rows_act);

	always_comb begin
		unique case (action) inside
			ACT_SET, ACT_CLEAR, ACT_TOGGLE, ACT_READ: cell_cmd = 1'b1;
			default:                                  cell_cmd = 1'b0;
		endcase
	end

	// sweep control: read rows 0..h, write row j-1 when row j arrives
	assign gen_issue = (state_q == ST_GEN) && (ptr_q <= rows_act);
	assign gen_done  = gen_s1_q && (ptr_s1 == rows_act);
	assign push_ok   = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			gen_s1_q <= 1'b0;
		end else begin
			gen_s1_q <= gen_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (cell_cmd && !coord_bad) begin
							state_q <= ST_CELL;
						end else if (action == ACT_ADVANCE) begin
							state_q <= ST_GEN;
							ptr_q   <= '0;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_CELL: state_q <= ST_PUSH;
				ST_GEN: begin
					if (gen_issue) begin
						ptr_q <= ptr_q + CFG_W'(1);
					end
					if (gen_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the command and its pending result
	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q       <= action;
			col_q       <= col;
			row_q       <= row;
			res_value_q <= 1'b0;
			res_err_q   <= cell_cmd && coord_bad;
		end else if (state_q == ST_CELL) begin
			res_value_q <= new_bit;
		end
	end

	// row valid flags: wipe drops all, every write marks its row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (in_accept && (action == ACT_WIPE)) begin
			row_valid_q <= '0;
		end else if (ram_we) begin
			row_valid_q[ram_waddr] <= 1'b1;
		end
	end

	// RAM read side
	assign ram_re    = (in_accept && cell_cmd && !coord_bad) || gen_issue;
	assign ram_raddr = (state_q == ST_IDLE) ? row : ptr_q[ROW_AW-1:0];

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_vld_s1 <= row_valid_q[ram_raddr];
			ptr_s1    <= ptr_q;
		end
	end

	assign row_s1 = rd_vld_s1 ? ram_rdata : '0;

	// read-modify-write of one cell
	assign old_bit = row_s1[col_q];

	always_comb begin
		case (act_q)
			ACT_SET:    new_bit = 1'b1;
			ACT_CLEAR:  new_bit = 1'b0;
			ACT_TOGGLE: new_bit = ~old_bit;
			default:    new_bit = old_bit;
		endcase
	end

	always_comb begin
		cell_row        = row_s1;
		cell_row[col_q] = new_bit;
	end

	// RAM write side
	always_comb begin
		if (state_q == ST_CELL) begin
			ram_we    = (act_q != ACT_READ);
			ram_waddr = row_q;
			ram_wdata = cell_row;
		end else begin
			ram_we    = (state_q == ST_GEN) && gen_s1_q && (ptr_s1 != '0);
			ram_waddr = ROW_AW'(ptr_s1 - CFG_W'(1));
			ram_wdata = next_row;
		end
	end

	lcag_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// feed the chain; rows past the last row in use enter as dead
	assign cell_ctl = '{clear: in_accept && (action == ACT_ADVANCE),
		shift: (state_q == ST_GEN) && gen_s1_q};

	always_comb begin
		for (int i = 0; i < MAX_COLS; i++) begin
			col_active[i] = (i < int'(cols_act));
			bot_raw[i]    = (ptr_s1 < rows_act) ? row_s1[i] : 1'b0;
		end
	end

	// chain of column cells, each seeing its two neighbours
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		win_t left_bits;
		win_t right_bits;

		if (c == 0) begin : g_left_edge
			assign left_bits = '0;
		end else begin : g_left
			assign left_bits = own_bits[c-1];
		end

		if (c == MAX_COLS - 1) begin : g_right_edge
			assign right_bits = '0;
		end else begin : g_right
			assign right_bits = own_bits[c+1];
		end

		lcag_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl),
			.bot_raw (bot_raw[c]),
			.active  (col_active[c]),
			.left    (left_bits),
			.right   (right_bits),
			.own     (own_bits[c]),
			.next_bit(next_row[c])
		);
	end

	// output register: load the pending result, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_PUSH) && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && push_ok) begin
			cell_value_q  <= res_value_q;
			coord_error_q <= res_err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_value  = cell_value_q;
	assign coord_error = coord_error_q;

	// checks
	`LCAG_ASSERT_NOW(a_idle_no_write, (state_q == ST_IDLE), !ram_we, "grid written while idle")
	`LCAG_ASSERT_NOW(a_gen_row_in_use, (state_q == ST_GEN) && ram_we, ({1'b0, ram_waddr} < rows_act), "sweep wrote a row outside the grid in use")
	`LCAG_ASSERT_NOW(a_beat_from_push, $rose(out_valid_q), ($past(state_q) == ST_PUSH), "result beat raised outside push")
	`LCAG_ASSERT_NEXT(a_accept_busy, in_accept, (state_q != ST_IDLE), "accepted command left the core idle")

endmodule

`default_nettype wire

// ----- rtl/core/lcag_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lcag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lcag_cell.sv -----
// One column cell of the generation chain: holds two window rows of its column
// and applies B3/S23 from its neighbours' bits. Depends on lcag_pkg.
`default_nettype none

module lcag_cell
	import lcag_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      bot_raw,
	input  wire logic      active,
	input  wire win_t      left,
	input  wire win_t      right,
	output win_t           own,
	output logic           next_bit
);

	logic             top_q;
	logic             mid_q;
	logic [CNT_W-1:0] count;

	// advance the window one row down, or empty it before a sweep
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			top_q <= 1'b0;
			mid_q <= 1'b0;
		end else if (ctl.shift) begin
			top_q <= mid_q;
			mid_q <= bot_raw;
		end
	end

	// columns outside the grid in use look dead to everybody
	assign own = '{top: top_q & active, mid: mid_q & active, bot: bot_raw & active};

	// count the eight neighbours
	assign count = CNT_W'(left.top) + CNT_W'(left.mid) + CNT_W'(left.bot)
		+ CNT_W'(right.top) + CNT_W'(right.mid) + CNT_W'(right.bot)
		+ CNT_W'(own.top) + CNT_W'(own.bot);

	// apply the rule; keep the stored bit where the column is not in use
	always_comb begin
		if (!active) begin
			next_bit = mid_q;
		end else if (count == BIRTH_COUNT) begin
			next_bit = 1'b1;
		end else if (count == KEEP_COUNT) begin
			next_bit = mid_q;
		end else begin
			next_bit = 1'b0;
		end
	end

endmodule

`default_nettype wire
